// ----- src/ctn_pkg.sv -----
// ----------------------------------------------------------------------------
// ctn_pkg
// Shared types and constants for the cell-to-node weighted average block.
// ----------------------------------------------------------------------------
package ctn_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_ADD    = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int SUM_W = 64;
    localparam int WGT_W = 48;

    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  corner_node_0;
        logic [9:0]  corner_node_1;
        logic [9:0]  corner_node_2;
        logic [9:0]  corner_node_3;
        logic [31:0] cell_volume;
        logic signed [31:0] cell_value;
        logic        skip_cell;
        logic [9:0]  query_node;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] node_average;
        logic        has_weight;
    } res_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [47:0] divisor;
    } div_req_t;

endpackage

// ----- src/ctn_div.sv -----
// ----------------------------------------------------------------------------
// ctn_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctn_div
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctn_pkg::div_req_t    req,
    output logic                 done,
    output logic [63:0]          quotient
);

    logic [63:0] q_reg, q_next;
    logic [48:0] r_reg, r_next;
    logic [47:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [48:0] trial;
    logic [48:0] sub;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[47:0], q_reg[63]};
        sub       = trial - {1'b0, d_reg};
        if (req.start)
        begin
            q_next    = req.dividend;
            r_next    = '0;
            d_next    = req.divisor;
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!sub[48])
            begin
                r_next = sub;
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- src/cell_to_node_weighted_average.sv -----
// ----------------------------------------------------------------------------
// cell_to_node_weighted_average
// Spreads cell values onto mesh nodes by volume-weighted averaging.
// ----------------------------------------------------------------------------
// An add-cell keeps busy high through setup states ST_MUL and ST_NEG, then ST_CRD per
// corner, plus ST_CWR if in range; a skipped cell or an unused command keeps busy low.
// A read steps through ST_RRD, ST_RDV, ST_RWT for the bit-serial divider and ST_ROUT;
// without weight it skips ST_RWT. A clear sweeps the node memory one entry per cycle.
// After reset the same clearing pass runs first; busy stays high during it.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
module cell_to_node_weighted_average
#(
    parameter int MAX_NODES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ctn_pkg::cmd_t     cmd,
    output logic              result_valid,
    output ctn_pkg::res_t     result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [10:0]       cfg_data
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    localparam logic [3:0] ST_CLR  = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_NEG  = 4'd3;
    localparam logic [3:0] ST_CRD  = 4'd4;
    localparam logic [3:0] ST_CWR  = 4'd5;
    localparam logic [3:0] ST_RRD  = 4'd6;
    localparam logic [3:0] ST_RDV  = 4'd7;
    localparam logic [3:0] ST_RWT  = 4'd8;
    localparam logic [3:0] ST_ROUT = 4'd9;

    logic [63:0] sum_mem [MAX_NODES];
    logic [47:0] wgt_mem [MAX_NODES];
    logic [63:0] sum_rd;
    logic [47:0] wgt_rd;

    logic [3:0]  state_reg, state_next;
    logic [AW:0] clr_reg, clr_next;
    logic [10:0] niu_reg;
    ctn_pkg::cmd_t cmd_reg;
    logic [63:0] prod_reg, prod_next;
    logic [1:0]  k_reg, k_next;
    logic        neg_reg, neg_next;
    logic        rv_reg, rv_next;
    ctn_pkg::res_t res_reg, res_next;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0] wsum;
    logic [47:0] wwgt;

    logic [9:0]  corner;
    logic [15:0] corner_x;
    logic [15:0] query_x;
    logic [16:0] limit;
    logic [31:0] mag;
    logic [63:0] s_new;
    logic [48:0] w_new;
    ctn_pkg::div_req_t dreq;
    logic        ddone;
    logic [63:0] dq;

    assign limit = ({6'd0, niu_reg} < 17'(MAX_NODES)) ? {6'd0, niu_reg} : 17'(MAX_NODES);

    always_comb
    begin
        case (k_reg)
            2'd0:    corner = cmd_reg.corner_node_0;
            2'd1:    corner = cmd_reg.corner_node_1;
            2'd2:    corner = cmd_reg.corner_node_2;
            default: corner = cmd_reg.corner_node_3;
        endcase
    end

    assign corner_x = {6'd0, corner};
    assign query_x  = {6'd0, cmd_reg.query_node};

    assign mag   = cmd_reg.cell_value[31] ? (32'd0 - cmd_reg.cell_value) : cmd_reg.cell_value;
    assign s_new = sum_rd + prod_reg;
    assign w_new = {1'b0, wgt_rd} + {17'd0, cmd_reg.cell_volume};

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        prod_next  = prod_reg;
        k_next     = k_reg;
        neg_next   = neg_reg;
        rv_next    = 1'b0;
        res_next   = res_reg;
        we         = 1'b0;
        waddr      = corner_x[AW-1:0];
        raddr      = corner_x[AW-1:0];
        wsum       = '0;
        wwgt       = '0;
        dreq       = '0;
        case (state_reg)
            ST_CLR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(MAX_NODES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.command)
                        ctn_pkg::CMD_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLR;
                        end
                        ctn_pkg::CMD_ADD:
                            if (!cmd.skip_cell)
                                state_next = ST_MUL;
                        ctn_pkg::CMD_READ:
                            state_next = ST_RRD;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:
            begin
                prod_next  = {32'd0, cmd_reg.cell_volume} * {32'd0, mag};
                neg_next   = cmd_reg.cell_value[31];
                state_next = ST_NEG;
            end
            ST_NEG:
            begin
                if (neg_reg)
                    prod_next = 64'd0 - prod_reg;
                k_next     = 2'd0;
                state_next = ST_CRD;
            end
            ST_CRD:
            begin
                if ({7'd0, corner} < limit)
                    state_next = ST_CWR;
                else if (k_reg == 2'd3)
                    state_next = ST_IDLE;
                else
                    k_next = k_reg + 2'd1;
            end
            ST_CWR:
            begin
                we = 1'b1;
                if ((sum_rd[63] == prod_reg[63]) && (s_new[63] != sum_rd[63]))
                    wsum = prod_reg[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                else
                    wsum = s_new;
                wwgt = w_new[48] ? 48'hFFFF_FFFF_FFFF : w_new[47:0];
                if (k_reg == 2'd3)
                    state_next = ST_IDLE;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_CRD;
                end
            end
            ST_RRD:
            begin
                raddr      = query_x[AW-1:0];
                state_next = ST_RDV;
            end
            ST_RDV:
            begin
                if (({7'd0, cmd_reg.query_node} < limit) && (wgt_rd != 48'd0))
                begin
                    neg_next      = sum_rd[63];
                    dreq.start    = 1'b1;
                    dreq.dividend = sum_rd[63] ? (64'd0 - sum_rd) : sum_rd;
                    dreq.divisor  = wgt_rd;
                    state_next    = ST_RWT;
                end
                else
                begin
                    res_next   = '0;
                    rv_next    = 1'b1;
                    state_next = ST_ROUT;
                end
            end
            ST_RWT:
            begin
                if (ddone)
                begin
                    res_next.has_weight = 1'b1;
                    if (neg_reg)
                        res_next.node_average = (dq > 64'h8000_0000) ? 32'h8000_0000
                                                : (32'd0 - dq[31:0]);
                    else
                        res_next.node_average = (dq > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                : dq[31:0];
                    rv_next    = 1'b1;
                    state_next = ST_ROUT;
                end
            end
            ST_ROUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    ctn_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .done     (ddone),
        .quotient (dq)
    );

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            sum_mem[waddr] <= wsum;
            wgt_mem[waddr] <= wwgt;
        end
        sum_rd <= sum_mem[raddr];
        wgt_rd <= wgt_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg   <= '0;
            niu_reg   <= 11'd1024;
            rv_reg    <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
            k_reg     <= k_next;
            if (cfg_valid && cfg_ready)
                niu_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
        if (start && state_reg == ST_IDLE)
            cmd_reg <= cmd;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign cfg_ready    = (state_reg == ST_IDLE);
    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

// ----- src/ctn_checker.sv -----
// ----------------------------------------------------------------------------
// ctn_checker
// Port-level checks for the cell-to-node weighted average block.
// ----------------------------------------------------------------------------
module ctn_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input ctn_pkg::cmd_t cmd,
    input logic          result_valid,
    input ctn_pkg::res_t result
);

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid) else $error("Result strobe held.");

    a_zero_no_weight: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.has_weight) |-> (result.node_average == 32'sd0))
        else $error("Nonzero average without weight.");

    a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy) else $error("Result while idle.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((cmd.command == ctn_pkg::CMD_READ)
                            || (cmd.command == ctn_pkg::CMD_CLEAR))) |=> busy)
        else $error("Busy not raised after transfer.");

endmodule

bind cell_to_node_weighted_average ctn_checker u_ctn_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
);

// ----- test/cell_to_node_weighted_average_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cell_to_node_weighted_average_test
// Drives clear, add-cell and read commands into the averaging block and
// compares every read result with a predicted per-node weighted average.
// ----------------------------------------------------------------------------
module cell_to_node_weighted_average_test;

    localparam int NODES = 1024;
    localparam int WATCH_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    ctn_pkg::cmd_t cmd;
    logic result_valid;
    ctn_pkg::res_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [10:0] cfg_data;

    logic [63:0] sum_mem [NODES];
    logic [47:0] wgt_mem [NODES];
    logic [10:0] active_nodes;
    ctn_pkg::res_t avg_queue [$];
    int errors;
    int reads_checked;
    int items_sent;
    int idle_cycles;

    cell_to_node_weighted_average u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result_valid(result_valid), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    function automatic logic [63:0] add_sat64(input logic [63:0] s, input logic [63:0] d);
        logic [63:0] r;
        r = s + d;
        if (((s ^ r) & (d ^ r)) >> 63)
            return d[63] ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
        return r;
    endfunction

    task automatic predict(input ctn_pkg::cmd_t c);
        logic [63:0] mag;
        logic [63:0] term;
        logic [63:0] q;
        logic [48:0] w;
        logic [9:0] n;
        ctn_pkg::res_t r;
        case (c.command)
            ctn_pkg::CMD_CLEAR:
                for (int i = 0; i < NODES; i++)
                begin
                    sum_mem[i] = '0;
                    wgt_mem[i] = '0;
                end
            ctn_pkg::CMD_ADD:
                if (!c.skip_cell)
                begin
                    mag = c.cell_value[31] ? 64'h100000000 - {32'd0, c.cell_value}
                                           : {32'd0, c.cell_value};
                    term = {32'd0, c.cell_volume} * mag;
                    if (c.cell_value[31])
                        term = -term;
                    for (int k = 0; k < 4; k++)
                    begin
                        n = (k == 0) ? c.corner_node_0 : (k == 1) ? c.corner_node_1 :
                            (k == 2) ? c.corner_node_2 : c.corner_node_3;
                        if (n < active_nodes)
                        begin
                            sum_mem[n] = add_sat64(sum_mem[n], term);
                            w = wgt_mem[n] + c.cell_volume;
                            wgt_mem[n] = w[48] ? 48'hFFFFFFFFFFFF : w[47:0];
                        end
                    end
                end
            ctn_pkg::CMD_READ:
            begin
                n = c.query_node;
                r = '0;
                if (n < active_nodes && wgt_mem[n] != 0)
                begin
                    r.has_weight = 1'b1;
                    mag = sum_mem[n][63] ? -sum_mem[n] : sum_mem[n];
                    q = mag / {16'd0, wgt_mem[n]};
                    if (sum_mem[n][63])
                        r.node_average = (q > 64'h80000000) ? 32'h80000000 : 32'(-q);
                    else
                        r.node_average = (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
                end
                avg_queue = {avg_queue, r};
            end
            default: ;
        endcase
    endtask

    task automatic send(input ctn_pkg::cmd_t c);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict(c);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (avg_queue.size() != 0) @(negedge clk);
        while (busy) @(negedge clk);
        repeat (100) @(negedge clk);
        while (busy) @(negedge clk);
    endtask

    task automatic write_nodes(input logic [10:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        active_nodes = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic ctn_pkg::cmd_t make_cmd(input logic [1:0] op, input int span);
        ctn_pkg::cmd_t c;
        c = '0;
        c.command = op;
        c.corner_node_0 = 10'($urandom_range(0, span - 1));
        c.corner_node_1 = 10'($urandom_range(0, span - 1));
        c.corner_node_2 = 10'($urandom_range(0, span - 1));
        c.corner_node_3 = 10'($urandom_range(0, span - 1));
        c.query_node = 10'($urandom_range(0, span - 1));
        c.skip_cell = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
            0: c.cell_volume = $urandom_range(0, 255);
            1: c.cell_volume = 32'hFFFFFFFF - $urandom_range(0, 3);
            default: c.cell_volume = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: c.cell_value = 32'sh80000000 + $urandom_range(0, 3);
            1: c.cell_value = 32'sh7FFFFFFF - $urandom_range(0, 3);
            default: c.cell_value = $urandom;
        endcase
        return c;
    endfunction

    task automatic test_directed();
        ctn_pkg::cmd_t c;
        c = '0;
        c.command = ctn_pkg::CMD_READ;
        send(c);
        c = '0;
        c.command = ctn_pkg::CMD_ADD;
        c.corner_node_0 = 10'd0;
        c.corner_node_1 = 10'd0;
        c.corner_node_2 = 10'd1023;
        c.corner_node_3 = 10'd5;
        c.cell_volume = 32'hFFFFFFFF;
        c.cell_value = 32'sh7FFFFFFF;
        send(c);
        send(c);
        c.cell_value = 32'sh80000000;
        c.corner_node_0 = 10'd7;
        send(c);
        c.cell_volume = 32'd0;
        c.corner_node_1 = 10'd9;
        send(c);
        c.cell_volume = 32'd3;
        c.skip_cell = 1'b1;
        c.corner_node_1 = 10'd8;
        send(c);
        c = '0;
        c.command = ctn_pkg::CMD_READ;
        c.query_node = 10'd0;    send(c);
        c.query_node = 10'd5;    send(c);
        c.query_node = 10'd7;    send(c);
        c.query_node = 10'd8;    send(c);
        c.query_node = 10'd9;    send(c);
        c.query_node = 10'd1023; send(c);
        c = '0;
        c.command = ctn_pkg::CMD_UNUSED;
        c.query_node = 10'h3FF;
        send(c);
        c = '0;
        c.command = ctn_pkg::CMD_CLEAR;
        send(c);
        c.command = ctn_pkg::CMD_READ;
        send(c);
    endtask

    task automatic test_node_limits();
        ctn_pkg::cmd_t c;
        write_nodes(11'd0);
        c = make_cmd(ctn_pkg::CMD_ADD, 4);
        c.skip_cell = 1'b0;
        send(c);
        c.command = ctn_pkg::CMD_READ;
        send(c);
        write_nodes(11'd1);
        c = make_cmd(ctn_pkg::CMD_ADD, 2);
        c.skip_cell = 1'b0;
        c.corner_node_0 = 10'd0;
        c.corner_node_1 = 10'd1;
        send(c);
        c.command = ctn_pkg::CMD_READ;
        c.query_node = 10'd0; send(c);
        c.query_node = 10'd1; send(c);
        write_nodes(11'd2047);
        c.query_node = 10'd1; send(c);
    endtask

    task automatic run_random(input int count, input int span);
        ctn_pkg::cmd_t c;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55) c = make_cmd(ctn_pkg::CMD_ADD, span);
            else if (pick < 97) c = make_cmd(ctn_pkg::CMD_READ, span);
            else if (pick < 98) c = make_cmd(ctn_pkg::CMD_CLEAR, span);
            else c = make_cmd(ctn_pkg::CMD_UNUSED, span);
            if ($urandom_range(0, 3) == 0)
            begin
                c.corner_node_0 = 10'($urandom);
                c.query_node = 10'($urandom);
            end
            send(c);
        end
    endtask

    task automatic test_random();
        write_nodes(11'd1024);
        run_random(600, 16);
        write_nodes(11'd12);
        run_random(400, 16);
        write_nodes(11'd1000);
        run_random(400, 1024);
        write_nodes(11'd1024);
        run_random(400, 64);
    endtask

    always @(posedge clk)
    begin
        ctn_pkg::res_t want;
        if (rst_n && result_valid)
        begin
            if (avg_queue.size() == 0)
                report("unexpected result", result.node_average, 32'd0);
            else
            begin
                want = avg_queue.pop_front();
                reads_checked++;
                if (result.node_average !== want.node_average)
                    report("node_average", result.node_average, want.node_average);
                if (result.has_weight !== want.has_weight)
                    report("has_weight", {31'd0, result.has_weight},
                           {31'd0, want.has_weight});
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT)
        begin
            $display("watchdog timeout");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        reads_checked = 0;
        items_sent = 0;
        active_nodes = 11'd1024;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < NODES; i++)
        begin
            sum_mem[i] = '0;
            wgt_mem[i] = '0;
        end
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_node_limits();
        test_random();
        wait_drained();
        if (avg_queue.size() != 0)
            report("results left over", 32'(avg_queue.size()), 32'd0);
        $display("Sent %0d commands, checked %0d node averages.", items_sent, reads_checked);
        $display("Node counts 0, 1, 12, 1000, 1024 and 2047 were exercised.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
